// ----- hdl/hsa_pkg.sv -----
// ----------------------------------------------------------------------------
// hsa_pkg: shared types and constants for the hsv saturation adjust block
// Pixel structs, fixed-point widths, register indexes and the divider step.
// ----------------------------------------------------------------------------
`default_nettype none

package hsa_pkg;

	localparam int CH_W        = 16;
	localparam int NUM_CH      = 3;
	localparam int Q_SHIFT     = 12;
	localparam int N_W         = CH_W + Q_SHIFT;
	localparam int X_W         = 2 * CH_W + Q_SHIFT;
	localparam int XH_W        = 2 * CH_W;
	localparam int PROD_W      = 2 * CH_W + 1;
	localparam int SUM_W       = PROD_W + 1;
	localparam int DIV_BITS    = 4;
	localparam int DIV_STAGES  = CH_W / DIV_BITS;
	localparam int ARITH_STAGES = 5;
	localparam int PIPE_STAGES = ARITH_STAGES + DIV_STAGES;
	localparam int CFG_IDX_W   = 2;

	localparam int CH_BLUE  = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_RED   = 2;

	localparam logic [CH_W-1:0] SAT_OFFSET_RESET = 16'd0;
	localparam logic [CH_W-1:0] SAT_GAIN_RESET   = 16'd4506;

	localparam logic [CFG_IDX_W-1:0] CFG_SAT_OFFSET = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SAT_GAIN   = 2'd1;

	typedef logic [CH_W-1:0] chan_t;

	typedef struct packed {
		logic [CH_W-1:0] blue_in;
		logic [CH_W-1:0] green_in;
		logic [CH_W-1:0] red_in;
	} pixel_in_t;

	typedef struct packed {
		logic [CH_W-1:0] blue_out;
		logic [CH_W-1:0] green_out;
		logic [CH_W-1:0] red_out;
	} pixel_out_t;

	typedef struct packed {
		logic [CH_W-1:0] rem;
		logic            qbit;
	} div_step_t;

	// one restoring step: bring in the next dividend bit, subtract if it fits
	function automatic div_step_t div_step(input chan_t rem, input logic nbit,
			input chan_t den);
		logic [CH_W:0] trial;
		div_step_t     res;
		trial = {rem, nbit};
		if (trial >= {1'b0, den}) begin
			res.rem  = CH_W'(trial - {1'b0, den});
			res.qbit = 1'b1;
		end else begin
			res.rem  = trial[CH_W-1:0];
			res.qbit = 1'b0;
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/hsa_div.sv -----
// ----------------------------------------------------------------------------
// hsa_div: pipelined restoring divider
// Divides a 32-bit dividend by a 16-bit divisor whose quotient fits 16 bits,
// four quotient bits per stage, one new division accepted every cycle while its stage enables are set.
// ----------------------------------------------------------------------------
`default_nettype none

module hsa_div import hsa_pkg::*; (
	input  wire logic                  clk,
	input  wire logic [DIV_STAGES-1:0] stage_en,
	input  wire logic [XH_W-1:0]       dividend,
	input  wire chan_t                 divisor,
	output chan_t                      quotient
);

	chan_t rem_s [DIV_STAGES];
	chan_t lo_s  [DIV_STAGES];
	chan_t quo_s [DIV_STAGES];
	chan_t den_s [DIV_STAGES];

	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
		chan_t     rem_in, lo_in, quo_in, den_in;
		chan_t     rem_nx, lo_nx, quo_nx;
		div_step_t st;

		if (j == 0) begin : g_first
			// upper half is already below the divisor
			assign rem_in = dividend[XH_W-1:CH_W];
			assign lo_in  = dividend[CH_W-1:0];
			assign quo_in = '0;
			assign den_in = divisor;
		end else begin : g_next
			assign rem_in = rem_s[j-1];
			assign lo_in  = lo_s[j-1];
			assign quo_in = quo_s[j-1];
			assign den_in = den_s[j-1];
		end

		always_comb begin
			rem_nx = rem_in;
			lo_nx  = lo_in;
			quo_nx = quo_in;
			st     = '0;
			for (int b = 0; b < DIV_BITS; b++) begin
				st     = div_step(rem_nx, lo_nx[CH_W-1], den_in);
				rem_nx = st.rem;
				lo_nx  = {lo_nx[CH_W-2:0], 1'b0};
				quo_nx = {quo_nx[CH_W-2:0], st.qbit};
			end
		end

		always_ff @(posedge clk) begin
			if (stage_en[j]) begin
				rem_s[j] <= rem_nx;
				lo_s[j]  <= lo_nx;
				quo_s[j] <= quo_nx;
				den_s[j] <= den_in;
			end
		end
	end

	assign quotient = quo_s[DIV_STAGES-1];

endmodule

`default_nettype wire

// ----- hdl/hsv_saturation_adjust.sv -----
// ----------------------------------------------------------------------------
// hsv_saturation_adjust: hsv saturation remap of a 16-bit bgr pixel
// Pixels enter on src (src_valid, src_stall, src_pixel) and leave on dst
// (dst_valid, dst_stall, dst_pixel); an item moves when valid is high and
// stall is low. Saturation becomes clamp(offset + gain*S, 0, 1) with hue and
// value kept; offset and gain are signed Q4.12 registers written on the cfg
// port (index 0 offset, index 1 gain, other indexes ignored, cfg_ready is
// always high). Write them only while no item is in flight.
// Throughput is one pixel per clock while dst does not stall. Between acceptance and
// dst_valid lie five arithmetic stages (min/max, saturation products, clamp,
// channel products, numerator) and four stages of a radix-16 divider by the
// max-min span, one per channel.
// Each stage moves when its successor has room, so bubbles fill while dst
// stalls; src_stall rises only when all nine stages hold items and dst stalls.
// Reset empties the pipeline and sets offset to 0 and gain to 4506.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_saturation_adjust import hsa_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 src_valid,
	output logic                      src_stall,
	input  wire pixel_in_t            src_pixel,
	output logic                      dst_valid,
	input  wire logic                 dst_stall,
	output pixel_out_t                dst_pixel,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CH_W-1:0]      cfg_data
);

	logic signed [CH_W-1:0] sat_offset_q, sat_gain_q;

	logic [PIPE_STAGES-1:0] vld_q;
	logic [PIPE_STAGES-1:0] en;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_offset_q <= SAT_OFFSET_RESET;
			sat_gain_q   <= SAT_GAIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SAT_OFFSET: sat_offset_q <= cfg_data;
				CFG_SAT_GAIN:   sat_gain_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// a stage may load when it is empty or its successor loads
	always_comb begin
		en[PIPE_STAGES-1] = !vld_q[PIPE_STAGES-1] || !dst_stall;
		for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign src_stall = !en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) vld_q[0] <= src_valid;
			for (int k = 1; k < PIPE_STAGES; k++) begin
				if (en[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// stage 1: max, min, span
	chan_t ch_in [NUM_CH];
	chan_t vmax_c, vmin_c;
	chan_t ch_s1 [NUM_CH];
	chan_t vmax_s1, dist_s1;

	assign ch_in[CH_BLUE]  = src_pixel.blue_in;
	assign ch_in[CH_GREEN] = src_pixel.green_in;
	assign ch_in[CH_RED]   = src_pixel.red_in;

	always_comb begin
		vmax_c = ch_in[0];
		vmin_c = ch_in[0];
		for (int c = 1; c < NUM_CH; c++) begin
			if (ch_in[c] > vmax_c) vmax_c = ch_in[c];
			if (ch_in[c] < vmin_c) vmin_c = ch_in[c];
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			ch_s1   <= ch_in;
			vmax_s1 <= vmax_c;
			dist_s1 <= vmax_c - vmin_c;
		end
	end

	// stage 2: saturation products, per-channel weights
	// gray pixels use a span of one and hue zero: red weight 0, others 1
	logic                     gray_c;
	chan_t                    deff_c;
	chan_t                    k_c [NUM_CH];
	logic signed [PROD_W-1:0] off_ext, gain_ext, vmax_ext, dist_ext;

	logic signed [PROD_W-1:0] prod_off_s2, prod_gain_s2;
	logic [XH_W-1:0]          dv_s2;
	chan_t                    deff_s2, vmax_s2;
	chan_t                    k_s2 [NUM_CH];

	assign gray_c   = (dist_s1 == '0);
	assign deff_c   = gray_c ? CH_W'(1) : dist_s1;
	assign off_ext  = {{(PROD_W-CH_W){sat_offset_q[CH_W-1]}}, sat_offset_q};
	assign gain_ext = {{(PROD_W-CH_W){sat_gain_q[CH_W-1]}}, sat_gain_q};
	assign vmax_ext = {{(PROD_W-CH_W){1'b0}}, vmax_s1};
	assign dist_ext = {{(PROD_W-CH_W){1'b0}}, dist_s1};

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			if (gray_c) k_c[c] = (c == CH_RED) ? CH_W'(0) : CH_W'(1);
			else        k_c[c] = vmax_s1 - ch_s1[c];
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			prod_off_s2  <= off_ext * vmax_ext;
			prod_gain_s2 <= gain_ext * dist_ext;
			dv_s2        <= {{(XH_W-CH_W){1'b0}}, deff_c} * {{(XH_W-CH_W){1'b0}}, vmax_s1};
			deff_s2      <= deff_c;
			vmax_s2      <= vmax_s1;
			k_s2         <= k_c;
		end
	end

	// stage 3: clamp numerator to 0..4096*V
	logic [SUM_W-1:0] nsum_c;
	logic [N_W-1:0]   ntop_c, nclamp_c;

	logic [N_W-1:0]   n_s3;
	logic [XH_W-1:0]  dv_s3;
	chan_t            deff_s3;
	chan_t            k_s3 [NUM_CH];

	assign nsum_c = {prod_off_s2[PROD_W-1], prod_off_s2}
		+ {prod_gain_s2[PROD_W-1], prod_gain_s2};
	assign ntop_c = {vmax_s2, {Q_SHIFT{1'b0}}};

	always_comb begin
		if (nsum_c[SUM_W-1])
			nclamp_c = '0;
		else if (nsum_c[PROD_W-1:0] > {{(PROD_W-N_W){1'b0}}, ntop_c})
			nclamp_c = ntop_c;
		else
			nclamp_c = nsum_c[N_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			n_s3    <= nclamp_c;
			dv_s3   <= dv_s2;
			deff_s3 <= deff_s2;
			k_s3    <= k_s2;
		end
	end

	// stage 4: channel reductions and rounded base d*(4096*V + 2048)
	logic [X_W-1:0] kn_s4 [NUM_CH];
	logic [X_W-1:0] base_s4;
	chan_t          deff_s4;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int c = 0; c < NUM_CH; c++) begin
				kn_s4[c] <= {{(X_W-CH_W){1'b0}}, k_s3[c]} * {{(X_W-N_W){1'b0}}, n_s3};
			end
			base_s4 <= {dv_s3, {Q_SHIFT{1'b0}}}
				+ X_W'({deff_s3, {(Q_SHIFT-1){1'b0}}});
			deff_s4 <= deff_s3;
		end
	end

	// stage 5: numerator, low twelve bits drop since the divisor is 4096*d
	logic [X_W-1:0]  diff_c [NUM_CH];
	logic [XH_W-1:0] xh_s5 [NUM_CH];
	chan_t           deff_s5;

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			diff_c[c] = base_s4 - kn_s4[c];
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			for (int c = 0; c < NUM_CH; c++) begin
				xh_s5[c] <= diff_c[c][X_W-1:Q_SHIFT];
			end
			deff_s5 <= deff_s4;
		end
	end

	// stages 6 to 9: one divider per channel
	chan_t quo [NUM_CH];

	for (genvar c = 0; c < NUM_CH; c++) begin : g_div
		hsa_div u_div (
			.clk      (clk),
			.stage_en (en[PIPE_STAGES-1:ARITH_STAGES]),
			.dividend (xh_s5[c]),
			.divisor  (deff_s5),
			.quotient (quo[c])
		);
	end

	assign dst_valid           = vld_q[PIPE_STAGES-1];
	assign dst_pixel.blue_out  = quo[CH_BLUE];
	assign dst_pixel.green_out = quo[CH_GREEN];
	assign dst_pixel.red_out   = quo[CH_RED];

`ifndef ASSERT_OFF
	// divider precondition: quotient fits sixteen bits
	a_div_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[ARITH_STAGES-1] |->
			(xh_s5[CH_BLUE][XH_W-1:CH_W] < deff_s5) &&
			(xh_s5[CH_GREEN][XH_W-1:CH_W] < deff_s5) &&
			(xh_s5[CH_RED][XH_W-1:CH_W] < deff_s5))
		else $error("divider dividend out of range");

	a_span_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[1] |-> (deff_s2 != '0))
		else $error("zero divisor entered pipeline");

	// back pressure reaches the source only with every stage occupied
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> ((&vld_q) && dst_stall))
		else $error("source stalled with room in pipeline");
`endif

endmodule

`default_nettype wire
